// File: rtl/core/ltbw_pkg.sv
// types and constants shared by the log time bucket wheel modules
`timescale 1ns / 1ps

package ltbw_pkg;

	localparam int BucketsPerGroup = 8;
	localparam int GroupCount      = 8;
	localparam int TimeBits        = 48;
	localparam int NumBuckets      = BucketsPerGroup * GroupCount;

	// field widths
	localparam int BucketW = 7;
	localparam int LogW    = 6;
	localparam int GroupW  = $clog2(GroupCount);

	// distance from the base at which the last group ends
	localparam int DeltaLimit = ((1 << GroupCount) - 1) * BucketsPerGroup;
	localparam int DeltaW     = $clog2(DeltaLimit);

	// bucket code for a block group with no predicted request
	localparam logic [BucketW-1:0] NotRequested = BucketW'(NumBuckets);

	// packed stream widths
	localparam int InDataW  = ((TimeBits + 1 + 7) / 8) * 8;
	localparam int OutDataW = ((BucketW + LogW + 1 + 1 + LogW + LogW + 7) / 8) * 8;

	typedef enum logic {
		ModeLookup = 1'b0,
		ModeShift  = 1'b1
	} mode_t;

	// rotation request from the top level to the bucket map
	typedef struct packed {
		logic              en;
		logic [GroupW-1:0] last_group;
	} rot_req_t;

endpackage

// File: rtl/core/ltbw_index.sv
// log-scale time to logical bucket index
`timescale 1ns / 1ps

module ltbw_index
	import ltbw_pkg::*;
(
	input  logic [TimeBits-1:0] time_slice,
	input  logic [TimeBits-1:0] base_slice,
	output logic [LogW-1:0]     logical_index,
	output logic                out_of_range
);

	logic                  after_base;
	logic [TimeBits-1:0]   delta;
	logic                  far;
	logic [DeltaW-1:0]     delta_lo;
	logic [GroupCount-1:0] q_plus1;
	logic [GroupW-1:0]     grp;
	logic [DeltaW-1:0]     grp_start;
	logic [DeltaW-1:0]     offset;

	always_comb begin
		after_base = time_slice > base_slice;
		delta      = time_slice - base_slice;
		far        = delta >= TimeBits'(DeltaLimit);
		delta_lo   = delta[DeltaW-1:0];
		q_plus1    = GroupCount'(delta_lo / BucketsPerGroup) + GroupCount'(1);

		// group is the position of the leading one of q + 1
		grp = '0;
		for (int k = 0; k < GroupCount; k++) begin
			if (q_plus1[k]) begin
				grp = GroupW'(k);
			end
		end

		grp_start = DeltaW'(((1 << grp) - 1) * BucketsPerGroup);
		offset    = (delta_lo - grp_start) >> grp;

		if (!after_base) begin
			logical_index = '0;
			out_of_range  = 1'b0;
		end else if (far) begin
			logical_index = '0;
			out_of_range  = 1'b1;
		end else begin
			logical_index = LogW'(int'(grp) * BucketsPerGroup) + LogW'(offset);
			out_of_range  = 1'b0;
		end
	end

endmodule

// File: rtl/core/ltbw_map.sv
// logical to physical bucket map with prefix rotation
`timescale 1ns / 1ps

module ltbw_map
	import ltbw_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  rot_req_t        rot,
	input  logic [LogW-1:0] rd_addr,
	output logic [LogW-1:0] rd_data,
	output logic [LogW-1:0] head,
	output logic [LogW-1:0] next
);

	logic [LogW-1:0] map_q [NumBuckets];

	assign rd_data = map_q[rd_addr];
	assign head    = map_q[0];
	assign next    = map_q[(NumBuckets > 1) ? 1 : 0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NumBuckets; i++) begin
				map_q[i] <= LogW'(i);
			end
		end else if (rot.en) begin
			for (int i = 0; i < NumBuckets; i++) begin
				if ((i / BucketsPerGroup) <= int'(rot.last_group)) begin
					// old first bucket goes to the end of the prefix
					if (i == (int'(rot.last_group) + 1) * BucketsPerGroup - 1) begin
						map_q[i] <= map_q[0];
					end else begin
						map_q[i] <= map_q[(i + 1) % NumBuckets];
					end
				end
			end
		end
	end

endmodule

// File: rtl/core/log_time_bucket_wheel.sv
// top level of the log time bucket wheel
`timescale 1ns / 1ps

// Maps a predicted access time slice to a priority bucket on a log-scale timing
// wheel of 8 groups of 8 buckets, each group twice as wide in time as the one
// before. A lookup transfer (tuser = 0) returns the physical bucket that holds
// the time, bucket 64 for a group with no request or a time beyond the last
// group, and bucket of logical 0 for a time at or before the base slice. A shift
// transfer (tuser = 1) advances the base slice by one when it lies below the
// given slice, rotates the affected prefix of groups by one place and reports
// which physical bucket merges into which, and whether more shifts are needed;
// the result carries tuser = 1 only when the base really moved. One transfer is
// taken every cycle while the result side keeps up: the item sits in an input
// register, the index math and the map rotation are worked out from the current
// state, and the result lands in an output register, from which it transfers
// whenever m_tready is high. A stall on the result side holds the input
// register and then drops s_tready. After reset the map is the identity and
// the base is zero.
module log_time_bucket_wheel
	import ltbw_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	// input stream
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [InDataW-1:0]  s_tdata,   // time_slice[47:0], requested[48], zero fill
	input  logic                s_tuser,   // mode: 0 lookup, 1 shift
	// result stream
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [OutDataW-1:0] m_tdata,   // bucket_id[6:0], logical_index[12:7],
	                                       // out_of_range[13], more_pending[14],
	                                       // merge_from[20:15], merge_into[26:21], zero fill
	output logic                m_tuser    // did_shift
);

	// input register
	logic                valid_s1;
	mode_t               mode_s1;
	logic [TimeBits-1:0] time_s1;
	logic                req_s1;

	// result register
	logic                out_valid_q;
	logic [BucketW-1:0]  bucket_q;
	logic [LogW-1:0]     logical_q;
	logic                oor_q;
	logic                did_shift_q;
	logic                more_q;
	logic [LogW-1:0]     from_q;
	logic [LogW-1:0]     into_q;

	// wheel state
	logic [TimeBits-1:0] base_q;

	logic                advance;
	logic                fire;
	logic [LogW-1:0]     li;
	logic                oor;
	logic [LogW-1:0]     map_rd;
	logic [LogW-1:0]     map_head;
	logic [LogW-1:0]     map_next;
	logic                shift_go;
	logic [TimeBits-1:0] next_base;
	logic [GroupW-1:0]   last_group;
	logic                low_zero;
	rot_req_t            rot;

	// the input register moves whenever the result register is free or emptying
	assign advance  = !out_valid_q || m_tready;
	assign s_tready = !valid_s1 || advance;
	assign fire     = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			mode_s1 <= mode_t'(s_tuser);
			time_s1 <= s_tdata[TimeBits-1:0];
			req_s1  <= s_tdata[TimeBits];
		end
	end

	ltbw_index u_index (
		.time_slice    (time_s1),
		.base_slice    (base_q),
		.logical_index (li),
		.out_of_range  (oor)
	);

	// shift decision and length of the rotated prefix
	always_comb begin
		shift_go   = (mode_s1 == ModeShift) && (time_s1 > base_q);
		next_base  = base_q + TimeBits'(1);
		last_group = '0;
		low_zero   = 1'b1;
		for (int k = 1; k < GroupCount; k++) begin
			low_zero = low_zero && !next_base[k-1];
			if (low_zero) begin
				last_group = GroupW'(k);
			end
		end
		rot.en         = fire && shift_go;
		rot.last_group = last_group;
	end

	ltbw_map u_map (
		.clk     (clk),
		.arst_n  (arst_n),
		.rot     (rot),
		.rd_addr (li),
		.rd_data (map_rd),
		.head    (map_head),
		.next    (map_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
		end else if (rot.en) begin
			base_q <= next_base;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (fire) begin
			bucket_q    <= '0;
			logical_q   <= '0;
			oor_q       <= 1'b0;
			did_shift_q <= 1'b0;
			more_q      <= 1'b0;
			from_q      <= '0;
			into_q      <= '0;
			if (mode_s1 == ModeLookup) begin
				if (!req_s1) begin
					bucket_q <= NotRequested;
				end else if (oor) begin
					bucket_q <= NotRequested;
					oor_q    <= 1'b1;
				end else begin
					bucket_q  <= BucketW'(map_rd);
					logical_q <= li;
				end
			end else if (shift_go) begin
				did_shift_q <= 1'b1;
				more_q      <= next_base < time_s1;
				from_q      <= map_head;
				into_q      <= map_next;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = did_shift_q;
	assign m_tdata  = OutDataW'({into_q, from_q, more_q, oor_q, logical_q, bucket_q});

endmodule

// File: tb/sv/tb_log_time_bucket_wheel.sv
// self-checking testbench for the log time bucket wheel
`timescale 1ns / 1ps

module tb_log_time_bucket_wheel;
	import ltbw_pkg::*;

	localparam int DrainCycles = 8;       // pipeline drain plus margin
	localparam int CycleLimit  = 400000;  // far above the slowest legal run
	localparam int PrintLimit  = 40;

	// one result as seen on the result stream
	typedef struct packed {
		logic [BucketW-1:0] bucket;
		logic [LogW-1:0]    logical;
		logic               oor;
		logic               shifted;
		logic               more;
		logic [LogW-1:0]    from;
		logic [LogW-1:0]    into;
	} wheel_result_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [InDataW-1:0]  s_tdata = '0;
	logic                s_tuser = 1'b0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [OutDataW-1:0] m_tdata;
	logic                m_tuser;

	// shadow copy of the wheel state, advanced on every input transfer that shifts
	logic [63:0]         shadow_base;
	logic [LogW-1:0]     shadow_map [NumBuckets];
	wheel_result_t       awaited_results [$];

	// base slice as the sender sees it, used to aim stimulus near the base
	logic [TimeBits-1:0] tx_base;

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int mismatch_count = 0;
	int cycle_count    = 0;

	log_time_bucket_wheel uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CycleLimit) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// result side backpressure
	always @(posedge clk) begin
		if (!arst_n)
			m_tready <= 1'b0;
		else
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// expected result of one item, updating the shadow state as the block does
	function automatic wheel_result_t next_wheel_result(input mode_t mode,
			input logic [TimeBits-1:0] ts_in, input logic req);
		wheel_result_t   r;
		logic [63:0]     ts, x, gstart, idx, nb;
		int              g, len;
		logic [LogW-1:0] spare, into;
		r = '0;
		ts = 64'(ts_in);
		if (mode == ModeLookup) begin
			if (!req) begin
				r.bucket = NotRequested;
			end else if (ts <= shadow_base) begin
				// at or before the base: first logical bucket
				r.bucket = BucketW'(shadow_map[0]);
			end else begin
				x = (ts - shadow_base) / BucketsPerGroup + 1;
				g = 0;
				while (x > 1) begin
					x = x >> 1;
					g++;
				end
				if (g >= GroupCount) begin
					r.bucket = NotRequested;
					r.oor = 1'b1;
				end else begin
					gstart = shadow_base + ((64'd1 << g) - 1) * BucketsPerGroup;
					idx = g * BucketsPerGroup + ((ts - gstart) >> g);
					if (idx >= NumBuckets) begin
						r.bucket = NotRequested;
						r.oor = 1'b1;
					end else begin
						r.bucket = BucketW'(shadow_map[idx]);
						r.logical = idx[LogW-1:0];
					end
				end
			end
		end else if (shadow_base < ts) begin
			nb = shadow_base + 1;
			spare = shadow_map[0];
			into = (NumBuckets > 1) ? shadow_map[1] : spare;
			// trailing zeros of the new base pick how many groups rotate
			g = 0;
			while (g + 1 < GroupCount && (nb & ((64'd1 << (g + 1)) - 1)) == 0)
				g++;
			len = (g + 1) * BucketsPerGroup;
			for (int i = 0; i + 1 < len; i++)
				shadow_map[i] = shadow_map[i + 1];
			shadow_map[len - 1] = spare;
			shadow_base = nb;
			r.shifted = 1'b1;
			r.more = (nb < ts);
			r.from = spare;
			r.into = into;
		end
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		mismatch_count++;
		if (mismatch_count <= PrintLimit)
			$display("%0t: %s: got %0d, want %0d", $realtime, what, got, want);
	endtask

	task automatic check_field(input string what, input logic [63:0] got,
			input logic [63:0] want);
		if (got !== want)
			report_mismatch(what, got, want);
	endtask

	// predict on every input transfer, compare on every result transfer
	always @(posedge clk) begin : result_check
		wheel_result_t got, want;
		if (arst_n) begin
			if (s_tvalid && s_tready)
				awaited_results.push_back(next_wheel_result(mode_t'(s_tuser),
					s_tdata[TimeBits-1:0], s_tdata[TimeBits]));
			if (m_tvalid && m_tready) begin
				got.bucket  = m_tdata[6:0];
				got.logical = m_tdata[12:7];
				got.oor     = m_tdata[13];
				got.more    = m_tdata[14];
				got.from    = m_tdata[20:15];
				got.into    = m_tdata[26:21];
				got.shifted = m_tuser;
				if (awaited_results.size() == 0) begin
					report_mismatch("result with nothing pending", 64'(got), 64'(0));
				end else begin
					want = awaited_results.pop_front();
					check_field("bucket_id", 64'(got.bucket), 64'(want.bucket));
					check_field("logical_index", 64'(got.logical), 64'(want.logical));
					check_field("out_of_range", 64'(got.oor), 64'(want.oor));
					check_field("did_shift", 64'(got.shifted), 64'(want.shifted));
					check_field("more_pending", 64'(got.more), 64'(want.more));
					check_field("merge_from", 64'(got.from), 64'(want.from));
					check_field("merge_into", 64'(got.into), 64'(want.into));
				end
			end
		end
	end

	// one input transfer; called right after a rising edge
	task automatic send_item(input mode_t mode, input logic [TimeBits-1:0] ts,
			input logic req);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= mode;
		s_tdata  <= InDataW'({req, ts});
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		if (mode == ModeShift && ts > tx_base)
			tx_base = tx_base + 1;
	endtask

	// sender holds off until every result is back
	task automatic wait_for_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (awaited_results.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	task automatic test_lookup_extremes();
		send_item(ModeLookup, 0, 1'b1);
		send_item(ModeLookup, 1, 1'b1);
		send_item(ModeLookup, 7, 1'b1);
		send_item(ModeLookup, 8, 1'b1);     // first bucket of the second group
		send_item(ModeLookup, 23, 1'b1);
		send_item(ModeLookup, 24, 1'b1);
		send_item(ModeLookup, DeltaLimit - 1, 1'b1);  // last bucket of the last group
		send_item(ModeLookup, DeltaLimit, 1'b1);      // just past the wheel
		send_item(ModeLookup, '1, 1'b1);
	endtask

	task automatic test_not_requested();
		send_item(ModeLookup, 0, 1'b0);
		send_item(ModeLookup, 5, 1'b0);
		send_item(ModeLookup, '1, 1'b0);
	endtask

	task automatic test_shift_rules();
		send_item(ModeShift, 0, 1'b0);   // base already there
		send_item(ModeShift, 1, 1'b0);   // advance, nothing more pending
		send_item(ModeShift, '1, 1'b1);  // advance, more pending
		send_item(ModeShift, 2, 1'b0);   // base equals time, no move
		send_item(ModeShift, 4, 1'b0);
		send_item(ModeShift, 4, 1'b0);   // base 4 rotates three groups
		send_item(ModeShift, 9, 1'b1);
		send_item(ModeLookup, 1, 1'b1);  // before the base
		send_item(ModeLookup, 5, 1'b1);  // at the base
		send_item(ModeLookup, 6, 1'b1);
		send_item(ModeLookup, 13, 1'b1);
		send_item(ModeLookup, 14, 1'b1);
	endtask

	task automatic test_random_traffic(input int count);
		int                  pick, g;
		logic [63:0]         lo, hi;
		logic [TimeBits-1:0] ts;
		mode_t               mode;
		logic                req;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(99);
			req = 1'b1;
			if (pick < 35) begin
				mode = ModeShift;
				req = 1'($urandom_range(1));
				case ($urandom_range(9))
					0: ts = tx_base;
					1: ts = TimeBits'($urandom_range(0, int'(tx_base)));
					2: ts = TimeBits'({$urandom(), $urandom()});
					default: ts = tx_base + $urandom_range(1, 4);
				endcase
			end else begin
				mode = ModeLookup;
				if (pick < 45) begin
					req = 1'b0;
					ts = TimeBits'({$urandom(), $urandom()});
				end else if (pick < 55) begin
					ts = TimeBits'({$urandom(), $urandom()});
				end else if (pick < 63) begin
					ts = TimeBits'($urandom_range(0, int'(tx_base)));
				end else begin
					// aim at one group, often at its edges
					g = $urandom_range(0, GroupCount);
					if (g == GroupCount) begin
						ts = tx_base + DeltaLimit + $urandom_range(0, 4000);
					end else begin
						lo = ((64'd1 << g) - 1) * BucketsPerGroup;
						hi = ((64'd1 << (g + 1)) - 1) * BucketsPerGroup - 1;
						case ($urandom_range(3))
							0: ts = TimeBits'(tx_base + lo);
							1: ts = TimeBits'(tx_base + hi);
							default: ts = TimeBits'(tx_base + lo
								+ $urandom_range(0, int'(hi - lo)));
						endcase
					end
				end
			end
			send_item(mode, ts, req);
		end
	endtask

	initial begin
		shadow_base = '0;
		tx_base = '0;
		for (int i = 0; i < NumBuckets; i++)
			shadow_map[i] = LogW'(i);
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct  = 28;
		recv_stall_pct = 76;
		test_lookup_extremes();
		test_not_requested();
		test_shift_rules();
		test_random_traffic(600);
		wait_for_results();

		send_idle_pct  = 76;
		recv_stall_pct = 28;
		test_random_traffic(600);
		wait_for_results();

		send_idle_pct  = 0;
		recv_stall_pct = 0;
		test_random_traffic(600);
		wait_for_results();

		if (mismatch_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
